// File: rtl/pga_pkg.sv
// Shared types, widths and constants of the Poincare gyromidpoint aggregate.
package pga_pkg;

  // Vector geometry
  localparam int MaxDim = 64;
  localparam int IdxW   = $clog2(MaxDim);
  localparam int DimW   = IdxW + 1;

  // Field and accumulator widths
  localparam int ValW   = 16;
  localparam int WgtW   = 16;
  localparam int CurvW  = 16;
  localparam int NumW   = 48;
  localparam int DenW   = 48;
  localparam int N2W    = 37;
  localparam int Cn2W   = 53;
  localparam int M2W    = 47;
  localparam int Cm2W   = 63;
  localparam int GamW   = 32;
  localparam int GwW    = 31;
  localparam int MeanW  = 21;
  localparam int DivW   = 64;
  localparam int DvsW   = 48;
  localparam int RadW   = 43;
  localparam int RootW  = 22;
  localparam int SdenW  = 23;

  // Configuration port
  localparam int CfgIdxW  = 1;
  localparam int CfgDataW = 16;
  localparam logic [CfgIdxW-1:0] RegCurvature = 1'b0;
  localparam logic [CfgIdxW-1:0] RegVecLen    = 1'b1;
  localparam logic [CurvW-1:0]   CurvReset    = 16'd4096;
  localparam logic [DimW-1:0]    VecLenReset  = 7'd64;

  // Arithmetic constants
  localparam logic [RadW-1:0]  OneQ42    = RadW'(1) << 42;
  localparam logic [DivW-1:0]  GammaNum  = DivW'(1) << 59;
  localparam logic [GamW-1:0]  GammaOne  = 32'h0001_0000;
  localparam logic [GamW-1:0]  GammaMax  = 32'hFFFF_FFFF;
  localparam logic [MeanW-1:0] MeanLim   = 21'h10_0000;
  localparam logic [SdenW-1:0] SdenBase  = SdenW'(1) << 21;
  localparam logic [NumW-1:0]  NumMax    = 48'h7FFF_FFFF_FFFF;
  localparam logic [NumW-1:0]  NumMin    = 48'h8000_0000_0000;
  localparam logic [DenW-1:0]  DenMax    = 48'hFFFF_FFFF_FFFF;

  // Datapath operations issued by the controller
  typedef enum logic [4:0] {
    OP_NONE,
    OP_ACCEPT,
    OP_RD,
    OP_N2_ACC,
    OP_CN2,
    OP_GDIV,
    OP_GTAKE,
    OP_GW,
    OP_ACC_MUL,
    OP_ACC_WR,
    OP_MEAN_DIV,
    OP_MEAN_WR,
    OP_CM2,
    OP_SQ,
    OP_SDEN,
    OP_OUT_DIV,
    OP_EMIT
  } op_e;

  typedef struct packed {
    op_e op;
  } cmd_t;

  typedef struct packed {
    logic row_end;
    logic last_d;
    logic fin;
    logic div_done;
    logic sqrt_done;
  } st_t;

endpackage

// File: rtl/pga_div.sv
// Radix-2 restoring divider, one quotient bit per cycle.
module pga_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [pga_pkg::DivW-1:0]  dividend_i,
  input  logic [pga_pkg::DvsW-1:0]  divisor_i,
  output logic                      done_o,
  output logic [pga_pkg::DivW-1:0]  quot_o
);

  logic [pga_pkg::DivW-1:0] dq_d, dq_q;
  logic [pga_pkg::DvsW-1:0] dvs_q;
  logic [pga_pkg::DvsW-1:0] rem_d, rem_q;
  logic [pga_pkg::DvsW:0]   trial;
  logic                     ge;
  logic [5:0]               cnt_q;
  logic                     busy_q, done_q;

  // One shift and trial subtraction per cycle.
  always_comb begin
    trial = {rem_q, dq_q[pga_pkg::DivW-1]};
    ge    = trial >= {1'b0, dvs_q};
    rem_d = ge ? pga_pkg::DvsW'(trial - {1'b0, dvs_q}) : trial[pga_pkg::DvsW-1:0];
    dq_d  = {dq_q[pga_pkg::DivW-2:0], ge};
  end

  // Step counter and completion pulse.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 6'd1;
        if (cnt_q == 6'd63) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Operand and partial remainder registers.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dq_q  <= dividend_i;
      dvs_q <= divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      dq_q  <= dq_d;
      rem_q <= rem_d;
    end
  end

  assign done_o = done_q;
  assign quot_o = dq_q;

endmodule

// File: rtl/pga_sqrt.sv
// Bit-serial integer square root, two radicand bits per cycle.
module pga_sqrt (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [pga_pkg::RadW-1:0]   radicand_i,
  output logic                       done_o,
  output logic [pga_pkg::RootW-1:0]  root_o
);

  logic [pga_pkg::RadW-1:0] v_q;
  logic [pga_pkg::RadW:0]   r_q;
  logic [pga_pkg::RadW-1:0] bit_q;
  logic [pga_pkg::RadW:0]   trial;
  logic                     busy_q, done_q;

  assign trial = r_q + {1'b0, bit_q};

  // Sequencing: the last step is the one with the lowest bit set.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
      end else if (busy_q && bit_q[0]) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  // Root recurrence.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      v_q   <= radicand_i;
      r_q   <= '0;
      bit_q <= pga_pkg::OneQ42;
    end else if (busy_q) begin
      if ({1'b0, v_q} >= trial) begin
        v_q <= pga_pkg::RadW'({1'b0, v_q} - trial);
        r_q <= (r_q >> 1) + {1'b0, bit_q};
      end else begin
        r_q <= r_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end
  end

  assign done_o = done_q;
  assign root_o = r_q[pga_pkg::RootW-1:0];

endmodule

// File: rtl/pga_dp.sv
// Datapath: row buffer, sums, conformal factor, mean and output scaling.
module pga_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  pga_pkg::cmd_t                 cmd_i,
  output pga_pkg::st_t                  st_o,
  input  logic                          cfg_we_i,
  input  logic [pga_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [pga_pkg::CfgDataW-1:0]  cfg_data_i,
  input  logic signed [pga_pkg::ValW-1:0] element_value_i,
  input  logic [pga_pkg::WgtW-1:0]      row_weight_i,
  input  logic                          final_row_i,
  output logic signed [pga_pkg::ValW-1:0] midpoint_value_o,
  output logic                          last_element_o,
  output logic                          valid_o
);

  // Configuration and control state
  logic [pga_pkg::CurvW-1:0]  curv_q;
  logic [pga_pkg::DimW-1:0]   vlen_q;
  logic [pga_pkg::IdxW-1:0]   idx_q;
  logic [pga_pkg::MaxDim-1:0] vld_q;
  logic [pga_pkg::DenW-1:0]   den_q;
  logic                       val_q;

  // Payload registers
  logic [pga_pkg::IdxW-1:0]   d_q;
  logic [pga_pkg::WgtW-1:0]   w_q;
  logic                       fin_q;
  logic signed [pga_pkg::ValW-1:0] buf_rd_q;
  logic [pga_pkg::NumW-1:0]   num_rd_q;
  logic [pga_pkg::N2W-1:0]    n2_q;
  logic [pga_pkg::Cn2W-1:0]   cn2_q;
  logic [pga_pkg::GamW-1:0]   gamma_q;
  logic [pga_pkg::GwW-1:0]    gw_q;
  logic signed [pga_pkg::NumW-1:0] prod_q;
  logic [pga_pkg::M2W-1:0]    m2_q;
  logic [pga_pkg::Cm2W-1:0]   cm2_q;
  logic [pga_pkg::SdenW-1:0]  sden_q;
  logic signed [pga_pkg::ValW-1:0] mid_q;
  logic                       last_q;

  // Memories
  logic signed [pga_pkg::ValW-1:0] buf_mem [pga_pkg::MaxDim];
  logic [pga_pkg::NumW-1:0]        num_mem [pga_pkg::MaxDim];

  // Combinational helpers
  logic [pga_pkg::DimW-1:0]  dim, dim_m1, idx_p1;
  logic [pga_pkg::IdxW-1:0]  last_idx;
  logic                      last_d;
  logic signed [31:0]        sq;
  logic                      cn2_gt, cn2_eq;
  logic [pga_pkg::RadW-1:0]  gdiv_dvs;
  logic [47:0]               gw_full, dinc_full;
  logic [pga_pkg::DenW:0]    den_sum;
  logic [pga_pkg::NumW:0]    acc_s;
  logic [pga_pkg::NumW-1:0]  acc_sat;
  logic [pga_pkg::NumW-1:0]  num_mag;
  logic [pga_pkg::MeanW-1:0] mq;
  logic [41:0]               mq_sq;
  logic [pga_pkg::NumW-1:0]  mean_w;
  logic [pga_pkg::RadW-1:0]  rad;
  logic [pga_pkg::ValW-1:0]  emit_v;
  logic                      div_go, div_done, sqrt_done;
  logic [pga_pkg::DivW-1:0]  div_a, div_q;
  logic [pga_pkg::DvsW-1:0]  div_b;
  logic [pga_pkg::RootW-1:0] root;

  // Vector length in use, clamped to the supported range.
  always_comb begin
    if (vlen_q == '0) begin
      dim = pga_pkg::DimW'(1);
    end else if (vlen_q > pga_pkg::DimW'(pga_pkg::MaxDim)) begin
      dim = pga_pkg::DimW'(pga_pkg::MaxDim);
    end else begin
      dim = vlen_q;
    end
  end

  assign dim_m1   = dim - pga_pkg::DimW'(1);
  assign last_idx = dim_m1[pga_pkg::IdxW-1:0];
  assign idx_p1   = {1'b0, idx_q} + pga_pkg::DimW'(1);
  assign last_d   = d_q == last_idx;

  assign st_o.row_end   = idx_p1 >= dim;
  assign st_o.last_d    = last_d;
  assign st_o.fin       = fin_q;
  assign st_o.div_done  = div_done;
  assign st_o.sqrt_done = sqrt_done;

  // Squared element for the norm.
  assign sq = buf_rd_q * buf_rd_q;

  // Divisor of the conformal factor and its special cases.
  always_comb begin
    cn2_gt   = (|cn2_q[pga_pkg::Cn2W-1:43]) || (cn2_q[42] && (|cn2_q[41:0]));
    cn2_eq   = cn2_q == pga_pkg::Cn2W'(pga_pkg::OneQ42);
    gdiv_dvs = pga_pkg::OneQ42 - {1'b0, cn2_q[41:0]};
  end

  // Weighted factor and denominator increment.
  assign gw_full   = gamma_q * w_q;
  assign dinc_full = (gamma_q - pga_pkg::GammaOne) * w_q;
  assign den_sum   = {1'b0, den_q} + pga_pkg::DenW'(dinc_full[47:16]);

  // Saturating numerator accumulation.
  always_comb begin
    acc_s = {num_rd_q[pga_pkg::NumW-1], num_rd_q} + {prod_q[pga_pkg::NumW-1], prod_q};
    if (acc_s[pga_pkg::NumW] != acc_s[pga_pkg::NumW-1]) begin
      acc_sat = acc_s[pga_pkg::NumW] ? pga_pkg::NumMin : pga_pkg::NumMax;
    end else begin
      acc_sat = acc_s[pga_pkg::NumW-1:0];
    end
  end

  // Mean coordinate from the divider quotient, clamped and signed.
  always_comb begin
    num_mag = num_rd_q[pga_pkg::NumW-1] ? (~num_rd_q + pga_pkg::NumW'(1)) : num_rd_q;
    mq      = (div_q > pga_pkg::DivW'(pga_pkg::MeanLim)) ? pga_pkg::MeanLim
                                                         : div_q[pga_pkg::MeanW-1:0];
    mq_sq   = mq * mq;
    mean_w  = num_rd_q[pga_pkg::NumW-1] ? (pga_pkg::NumW'(0) - pga_pkg::NumW'(mq))
                                        : pga_pkg::NumW'(mq);
  end

  // Radicand of the scaling root, floored at one.
  assign rad = (|cm2_q[pga_pkg::Cm2W-1:42]) ? pga_pkg::RadW'(1)
                                             : pga_pkg::OneQ42 - {1'b0, cm2_q[41:0]};

  // Output saturation with the sign of the mean.
  always_comb begin
    if (!num_rd_q[pga_pkg::NumW-1]) begin
      emit_v = (div_q > pga_pkg::DivW'(32767)) ? 16'h7FFF : div_q[pga_pkg::ValW-1:0];
    end else begin
      emit_v = (div_q > pga_pkg::DivW'(32768)) ? 16'h8000
                                               : (16'd0 - div_q[pga_pkg::ValW-1:0]);
    end
  end

  // Divider operand selection.
  always_comb begin
    div_a = '0;
    div_b = pga_pkg::DvsW'(1);
    case (cmd_i.op)
      pga_pkg::OP_GDIV: begin
        div_a = pga_pkg::GammaNum;
        div_b = (cn2_gt || cn2_eq) ? pga_pkg::DvsW'(1) : pga_pkg::DvsW'(gdiv_dvs);
      end
      pga_pkg::OP_MEAN_DIV: begin
        div_a = pga_pkg::DivW'(num_mag);
        div_b = (den_q == '0) ? pga_pkg::DvsW'(1) : den_q;
      end
      pga_pkg::OP_OUT_DIV: begin
        div_a = pga_pkg::DivW'({num_mag[pga_pkg::MeanW-1:0], 21'd0});
        div_b = pga_pkg::DvsW'(sden_q);
      end
      default: begin
      end
    endcase
  end

  assign div_go = cmd_i.op inside {pga_pkg::OP_GDIV, pga_pkg::OP_MEAN_DIV,
                                   pga_pkg::OP_OUT_DIV};

  pga_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_go),
    .dividend_i (div_a),
    .divisor_i  (div_b),
    .done_o     (div_done),
    .quot_o     (div_q)
  );

  pga_sqrt u_sqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.op == pga_pkg::OP_SQ),
    .radicand_i (rad),
    .done_o     (sqrt_done),
    .root_o     (root)
  );

  // Row buffer memory.
  always_ff @(posedge clk_i) begin
    if (cmd_i.op == pga_pkg::OP_ACCEPT) begin
      buf_mem[idx_q] <= element_value_i;
    end
    if (cmd_i.op == pga_pkg::OP_RD) begin
      buf_rd_q <= buf_mem[d_q];
    end
  end

  // Numerator memory; an entry without its valid bit reads as zero.
  always_ff @(posedge clk_i) begin
    if (cmd_i.op == pga_pkg::OP_ACC_WR) begin
      num_mem[d_q] <= acc_sat;
    end else if (cmd_i.op == pga_pkg::OP_MEAN_WR) begin
      num_mem[d_q] <= mean_w;
    end
    if (cmd_i.op == pga_pkg::OP_RD) begin
      num_rd_q <= vld_q[d_q] ? num_mem[d_q] : '0;
    end
  end

  // Configuration, element index, valid bits, denominator and result strobe.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      curv_q <= pga_pkg::CurvReset;
      vlen_q <= pga_pkg::VecLenReset;
      idx_q  <= '0;
      vld_q  <= '0;
      den_q  <= pga_pkg::DenW'(1);
      val_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          pga_pkg::RegCurvature: curv_q <= cfg_data_i;
          pga_pkg::RegVecLen:    vlen_q <= cfg_data_i[pga_pkg::DimW-1:0];
          default: begin
          end
        endcase
      end
      val_q <= cmd_i.op == pga_pkg::OP_EMIT;
      case (cmd_i.op)
        pga_pkg::OP_ACCEPT: begin
          idx_q <= st_o.row_end ? '0 : idx_p1[pga_pkg::IdxW-1:0];
        end
        pga_pkg::OP_GW: begin
          den_q <= den_sum[pga_pkg::DenW] ? pga_pkg::DenMax : den_sum[pga_pkg::DenW-1:0];
        end
        pga_pkg::OP_ACC_WR, pga_pkg::OP_MEAN_WR: begin
          vld_q[d_q] <= 1'b1;
        end
        pga_pkg::OP_EMIT: begin
          if (last_d) begin
            vld_q <= '0;
            den_q <= pga_pkg::DenW'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Arithmetic pipeline registers.
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      pga_pkg::OP_ACCEPT: begin
        w_q   <= row_weight_i;
        fin_q <= final_row_i;
        d_q   <= '0;
        n2_q  <= '0;
      end
      pga_pkg::OP_N2_ACC: begin
        n2_q <= n2_q + pga_pkg::N2W'(sq[30:0]);
        d_q  <= last_d ? '0 : d_q + pga_pkg::IdxW'(1);
      end
      pga_pkg::OP_CN2: begin
        cn2_q <= curv_q * n2_q;
      end
      pga_pkg::OP_GTAKE: begin
        if (cn2_gt) begin
          gamma_q <= pga_pkg::GammaOne;
        end else if (cn2_eq || (|div_q[pga_pkg::DivW-1:pga_pkg::GamW])) begin
          gamma_q <= pga_pkg::GammaMax;
        end else if (div_q[pga_pkg::DivW-1:16] == '0) begin
          gamma_q <= pga_pkg::GammaOne;
        end else begin
          gamma_q <= div_q[pga_pkg::GamW-1:0];
        end
      end
      pga_pkg::OP_GW: begin
        gw_q <= gw_full[46:16];
        m2_q <= '0;
      end
      pga_pkg::OP_ACC_MUL: begin
        prod_q <= $signed({1'b0, gw_q}) * buf_rd_q;
      end
      pga_pkg::OP_ACC_WR: begin
        d_q <= last_d ? '0 : d_q + pga_pkg::IdxW'(1);
      end
      pga_pkg::OP_MEAN_WR: begin
        m2_q <= m2_q + pga_pkg::M2W'(mq_sq);
        d_q  <= last_d ? '0 : d_q + pga_pkg::IdxW'(1);
      end
      pga_pkg::OP_CM2: begin
        cm2_q <= curv_q * m2_q;
      end
      pga_pkg::OP_SDEN: begin
        sden_q <= pga_pkg::SdenBase + pga_pkg::SdenW'(root);
      end
      pga_pkg::OP_EMIT: begin
        mid_q  <= emit_v;
        last_q <= last_d;
        d_q    <= last_d ? '0 : d_q + pga_pkg::IdxW'(1);
      end
      default: begin
      end
    endcase
  end

  assign midpoint_value_o = mid_q;
  assign last_element_o   = last_q;
  assign valid_o          = val_q;

endmodule

// File: rtl/pga_ctrl.sv
// Controller state machine that sequences the row and midpoint passes.
module pga_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  pga_pkg::st_t  st_i,
  output pga_pkg::cmd_t cmd_o,
  output logic          busy_o
);

  typedef enum logic [22:0] {
    S_IDLE      = 23'h000001,
    S_N2_RD     = 23'h000002,
    S_N2_ACC    = 23'h000004,
    S_CN2       = 23'h000008,
    S_GDIV      = 23'h000010,
    S_GWAIT     = 23'h000020,
    S_GTAKE     = 23'h000040,
    S_GW        = 23'h000080,
    S_ACC_RD    = 23'h000100,
    S_ACC_MUL   = 23'h000200,
    S_ACC_WR    = 23'h000400,
    S_MEAN_RD   = 23'h000800,
    S_MEAN_DIV  = 23'h001000,
    S_MEAN_WAIT = 23'h002000,
    S_MEAN_WR   = 23'h004000,
    S_CM2       = 23'h008000,
    S_SQ        = 23'h010000,
    S_SQ_WAIT   = 23'h020000,
    S_SDEN      = 23'h040000,
    S_OUT_RD    = 23'h080000,
    S_OUT_DIV   = 23'h100000,
    S_OUT_WAIT  = 23'h200000,
    S_OUT_EMIT  = 23'h400000
  } state_e;

  state_e state_d, state_q;

  // Next state and datapath command.
  always_comb begin
    state_d    = state_q;
    cmd_o.op   = pga_pkg::OP_NONE;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.op = pga_pkg::OP_ACCEPT;
          if (st_i.row_end) begin
            state_d = S_N2_RD;
          end
        end
      end
      S_N2_RD: begin
        cmd_o.op = pga_pkg::OP_RD;
        state_d  = S_N2_ACC;
      end
      S_N2_ACC: begin
        cmd_o.op = pga_pkg::OP_N2_ACC;
        state_d  = st_i.last_d ? S_CN2 : S_N2_RD;
      end
      S_CN2: begin
        cmd_o.op = pga_pkg::OP_CN2;
        state_d  = S_GDIV;
      end
      S_GDIV: begin
        cmd_o.op = pga_pkg::OP_GDIV;
        state_d  = S_GWAIT;
      end
      S_GWAIT: begin
        if (st_i.div_done) begin
          state_d = S_GTAKE;
        end
      end
      S_GTAKE: begin
        cmd_o.op = pga_pkg::OP_GTAKE;
        state_d  = S_GW;
      end
      S_GW: begin
        cmd_o.op = pga_pkg::OP_GW;
        state_d  = S_ACC_RD;
      end
      S_ACC_RD: begin
        cmd_o.op = pga_pkg::OP_RD;
        state_d  = S_ACC_MUL;
      end
      S_ACC_MUL: begin
        cmd_o.op = pga_pkg::OP_ACC_MUL;
        state_d  = S_ACC_WR;
      end
      S_ACC_WR: begin
        cmd_o.op = pga_pkg::OP_ACC_WR;
        if (!st_i.last_d) begin
          state_d = S_ACC_RD;
        end else begin
          state_d = st_i.fin ? S_MEAN_RD : S_IDLE;
        end
      end
      S_MEAN_RD: begin
        cmd_o.op = pga_pkg::OP_RD;
        state_d  = S_MEAN_DIV;
      end
      S_MEAN_DIV: begin
        cmd_o.op = pga_pkg::OP_MEAN_DIV;
        state_d  = S_MEAN_WAIT;
      end
      S_MEAN_WAIT: begin
        if (st_i.div_done) begin
          state_d = S_MEAN_WR;
        end
      end
      S_MEAN_WR: begin
        cmd_o.op = pga_pkg::OP_MEAN_WR;
        state_d  = st_i.last_d ? S_CM2 : S_MEAN_RD;
      end
      S_CM2: begin
        cmd_o.op = pga_pkg::OP_CM2;
        state_d  = S_SQ;
      end
      S_SQ: begin
        cmd_o.op = pga_pkg::OP_SQ;
        state_d  = S_SQ_WAIT;
      end
      S_SQ_WAIT: begin
        if (st_i.sqrt_done) begin
          state_d = S_SDEN;
        end
      end
      S_SDEN: begin
        cmd_o.op = pga_pkg::OP_SDEN;
        state_d  = S_OUT_RD;
      end
      S_OUT_RD: begin
        cmd_o.op = pga_pkg::OP_RD;
        state_d  = S_OUT_DIV;
      end
      S_OUT_DIV: begin
        cmd_o.op = pga_pkg::OP_OUT_DIV;
        state_d  = S_OUT_WAIT;
      end
      S_OUT_WAIT: begin
        if (st_i.div_done) begin
          state_d = S_OUT_EMIT;
        end
      end
      S_OUT_EMIT: begin
        cmd_o.op = pga_pkg::OP_EMIT;
        state_d  = st_i.last_d ? S_IDLE : S_OUT_RD;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = state_q != S_IDLE;

endmodule

// File: rtl/poincare_gyromidpoint_aggregate.sv
// Top level of the Poincare ball weighted gyromidpoint aggregate.
// A request (one vector element) is taken when start is high and busy is low; an element
// that does not end its row is absorbed without raising busy. The element that ends a row
// holds busy through two passes over the buffered row plus one division for the conformal
// factor. When that row is marked final, busy stays high on through the mean and output
// passes: every mean coordinate and every output coordinate goes through the same 64-step
// radix-2 divider, with a 22-step square root between the two passes. Results come out one
// coordinate at a time, each on the output ports for exactly one cycle with valid_o high,
// each after its own output division; the receiver cannot stall them, so it must take
// each one as it appears.
module poincare_gyromidpoint_aggregate (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  output logic                            busy,
  input  logic                            cfg_we_i,
  input  logic [pga_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [pga_pkg::CfgDataW-1:0]    cfg_data_i,
  input  logic signed [pga_pkg::ValW-1:0] element_value_i,
  input  logic [pga_pkg::WgtW-1:0]        row_weight_i,
  input  logic                            final_row_i,
  output logic signed [pga_pkg::ValW-1:0] midpoint_value_o,
  output logic                            last_element_o,
  output logic                            valid_o
);

  pga_pkg::cmd_t cmd;
  pga_pkg::st_t  st;

  // Sequencer.
  pga_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .st_i    (st),
    .cmd_o   (cmd),
    .busy_o  (busy)
  );

  // Arithmetic and storage.
  pga_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .st_o             (st),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .element_value_i  (element_value_i),
    .row_weight_i     (row_weight_i),
    .final_row_i      (final_row_i),
    .midpoint_value_o (midpoint_value_o),
    .last_element_o   (last_element_o),
    .valid_o          (valid_o)
  );

endmodule

// File: sim/poincare_gyromidpoint_aggregate_test.sv
// Self-checking testbench of the Poincare ball weighted gyromidpoint aggregate.
`timescale 1ns / 1ps

module poincare_gyromidpoint_aggregate_test;

  localparam int CycleLimit = 3_000_000;
  localparam int RandItems  = 380;

  typedef enum logic [1:0] {ROW_ITEM, ROW_CFG} row_kind_e;

  // One line of the directed stimulus table.
  typedef struct {
    row_kind_e   kind;
    logic [15:0] data;    // element value, or register data
    logic [15:0] weight;
    logic        fin_row;
    logic        cfg_sel; // register index
    logic        typed;   // expected coordinate typed in below
    logic [15:0] typed_val;
  } dir_row_t;

  typedef struct {
    logic signed [pga_pkg::ValW-1:0] coord;
    logic                            last;
  } midpoint_t;

  logic                            clk_i;
  logic                            rst_ni;
  logic                            start;
  logic                            busy;
  logic                            cfg_we_i;
  logic [pga_pkg::CfgIdxW-1:0]     cfg_idx_i;
  logic [pga_pkg::CfgDataW-1:0]    cfg_data_i;
  logic signed [pga_pkg::ValW-1:0] element_value_i;
  logic [pga_pkg::WgtW-1:0]        row_weight_i;
  logic                            final_row_i;
  logic signed [pga_pkg::ValW-1:0] midpoint_value_o;
  logic                            last_element_o;
  logic                            valid_o;

  poincare_gyromidpoint_aggregate dut (.*);

  // Predictor state: configuration, buffered row and running sums.
  longint unsigned   curv_q;
  int unsigned       len_reg;
  shortint           row_store [pga_pkg::MaxDim];
  int unsigned       elem_pos;
  longint            num_acc [pga_pkg::MaxDim];
  longint unsigned   den_acc;

  midpoint_t         midpoint_q [$];
  int                mismatches;
  int                results_seen;
  int                sets_done;
  longint            cycles;
  int                send_idle_pct;
  bit                gaps_on;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic int unsigned dims_used();
    if (len_reg < 1) return 1;
    if (len_reg > pga_pkg::MaxDim) return pga_pkg::MaxDim;
    return len_reg;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic void clear_sums();
    for (int d = 0; d < pga_pkg::MaxDim; d++) num_acc[d] = 0;
    den_acc = 1;
  endfunction

  // Folds one accepted element into the sums; on a final row pushes the midpoint.
  function automatic void fold_element(logic [15:0] x, logic [15:0] w, logic fin);
    int unsigned     dim;
    longint unsigned n2;
    longint          dvs;
    longint unsigned gam;
    longint          gw;
    longint          s;
    longint          mean [pga_pkg::MaxDim];
    longint unsigned m2;
    longint unsigned cm2;
    longint unsigned disc;
    longint unsigned mag;
    longint unsigned q;
    longint unsigned den;
    longint          sden;
    longint          v;
    midpoint_t       mp;
    dim = dims_used();
    if (elem_pos < pga_pkg::MaxDim) row_store[elem_pos] = shortint'(x);
    if (elem_pos + 1 < dim) begin
      elem_pos++;
      return;
    end
    elem_pos = 0;
    // Conformal factor of the row.
    n2 = 0;
    for (int d = 0; d < dim; d++) n2 += longint'(row_store[d]) * longint'(row_store[d]);
    dvs = longint'(64'd1 << 42) - longint'(curv_q * n2);
    if (dvs < 0) gam = 65536;
    else if (dvs == 0) gam = 64'hFFFF_FFFF;
    else begin
      gam = (64'd1 << 59) / unsigned'(dvs);
      if (gam > 64'hFFFF_FFFF) gam = 64'hFFFF_FFFF;
      if (gam < 65536) gam = 65536;
    end
    gw = longint'((gam * w) >> 16);
    for (int d = 0; d < dim; d++) begin
      s = num_acc[d] + gw * longint'(row_store[d]);
      if (s > 64'sh7FFF_FFFF_FFFF) s = 64'sh7FFF_FFFF_FFFF;
      if (s < -64'sh8000_0000_0000) s = -64'sh8000_0000_0000;
      num_acc[d] = s;
    end
    den_acc += ((gam - 65536) * w) >> 16;
    if (den_acc > 64'hFFFF_FFFF_FFFF) den_acc = 64'hFFFF_FFFF_FFFF;
    if (!fin) return;
    // Mean, Mobius scaling and emission.
    den = (den_acc != 0) ? den_acc : 1;
    m2 = 0;
    for (int d = 0; d < dim; d++) begin
      mag = (num_acc[d] < 0) ? unsigned'(-num_acc[d]) : unsigned'(num_acc[d]);
      q = mag / den;
      if (q > (64'd1 << 20)) q = 64'd1 << 20;
      mean[d] = (num_acc[d] < 0) ? -longint'(q) : longint'(q);
      m2 += q * q;
    end
    cm2 = curv_q * m2;
    disc = (cm2 >= (64'd1 << 42)) ? 1 : (64'd1 << 42) - cm2;
    sden = (64'sd1 << 21) + longint'(int_sqrt(disc));
    for (int d = 0; d < dim; d++) begin
      v = (mean[d] * (64'sd1 << 21)) / sden;
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      mp.coord = v[15:0];
      mp.last  = (d + 1 == dim);
      midpoint_q.push_back(mp);
    end
    sets_done++;
    clear_sums();
  endfunction

  // Result checker: every strobe is matched against the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && valid_o) begin
      results_seen++;
      if (midpoint_q.size() == 0) begin
        $error("unexpected result: midpoint_value %0d last_element %0b",
               midpoint_value_o, last_element_o);
        mismatches++;
      end else begin
        if (midpoint_value_o !== midpoint_q[0].coord) begin
          $error("midpoint_value: expected %0d, got %0d", midpoint_q[0].coord,
                 midpoint_value_o);
          mismatches++;
        end
        if (last_element_o !== midpoint_q[0].last) begin
          $error("last_element: expected %0b, got %0b", midpoint_q[0].last,
                 last_element_o);
          mismatches++;
        end
        void'(midpoint_q.pop_front());
      end
    end
  end

  // Issues one request and waits until it is taken.
  task automatic send_element(logic [15:0] x, logic [15:0] w, logic fin);
    start           <= 1'b1;
    element_value_i <= x;
    row_weight_i    <= w;
    final_row_i     <= fin;
    do @(posedge clk_i); while (busy);
    fold_element(x, w, fin);
    if (gaps_on && $urandom_range(99) < send_idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
  endtask

  // Register write once all work has drained.
  task automatic write_reg(logic sel, logic [15:0] val);
    start <= 1'b0;
    while (midpoint_q.size() != 0) @(posedge clk_i);
    do @(posedge clk_i); while (busy);
    repeat (4) @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= sel;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (sel == pga_pkg::RegCurvature) curv_q = val;
    else len_reg = val[6:0];
  endtask

  function automatic logic [15:0] rand_value();
    logic [15:0] x;
    x = 16'($urandom);
    // Smaller magnitudes keep the conformal factor away from its floor.
    return 16'($signed(x) >>> $urandom_range(0, 6));
  endfunction

  dir_row_t dir_rows [$];
  midpoint_t probe;

  initial begin
    logic [15:0] wgt;
    int          n_items;
    int          mode;
    start           = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_idx_i       = pga_pkg::RegCurvature;
    cfg_data_i      = '0;
    element_value_i = '0;
    row_weight_i    = '0;
    final_row_i     = 1'b0;
    rst_ni          = 1'b0;
    cycles          = 0;
    mismatches      = 0;
    results_seen    = 0;
    sets_done       = 0;
    gaps_on         = 1'b0;
    send_idle_pct   = 0;
    curv_q          = pga_pkg::CurvReset;
    len_reg         = pga_pkg::VecLenReset;
    elem_pos        = 0;
    for (int d = 0; d < pga_pkg::MaxDim; d++) row_store[d] = 0;
    clear_sums();

    // Directed table: extremes, saturation cases and length corner cases.
    dir_rows = '{
      '{ROW_CFG,  16'd1,     16'd0,     1'b0, pga_pkg::RegVecLen,    1'b0, 16'd0},
      '{ROW_ITEM, 16'd0,     16'd0,     1'b1, pga_pkg::RegCurvature, 1'b1, 16'd0},
      '{ROW_CFG,  16'd65535, 16'd0,     1'b0, pga_pkg::RegCurvature, 1'b0, 16'd0},
      '{ROW_ITEM, 16'h7FFF,  16'd32768, 1'b1, pga_pkg::RegCurvature, 1'b1, 16'h7FFF},
      '{ROW_ITEM, 16'h8000,  16'd32768, 1'b1, pga_pkg::RegCurvature, 1'b1, 16'h8000},
      '{ROW_CFG,  16'd4096,  16'd0,     1'b0, pga_pkg::RegCurvature, 1'b0, 16'd0},
      '{ROW_ITEM, 16'h8000,  16'd32768, 1'b0, pga_pkg::RegCurvature, 1'b0, 16'd0},
      '{ROW_ITEM, 16'h4000,  16'd1,     1'b1, pga_pkg::RegCurvature, 1'b0, 16'd0},
      '{ROW_CFG,  16'd0,     16'd0,     1'b0, pga_pkg::RegVecLen,    1'b0, 16'd0},
      '{ROW_ITEM, 16'd12345, 16'd1,     1'b1, pga_pkg::RegCurvature, 1'b0, 16'd0},
      '{ROW_CFG,  16'd1,     16'd0,     1'b0, pga_pkg::RegCurvature, 1'b0, 16'd0},
      '{ROW_CFG,  16'd3,     16'd0,     1'b0, pga_pkg::RegVecLen,    1'b0, 16'd0},
      '{ROW_ITEM, 16'h4000,  16'd5,     1'b1, pga_pkg::RegCurvature, 1'b0, 16'd0},
      '{ROW_ITEM, 16'hFFFF,  16'h7FFF,  1'b1, pga_pkg::RegCurvature, 1'b0, 16'd0},
      '{ROW_ITEM, 16'h7FFF,  16'd32768, 1'b0, pga_pkg::RegCurvature, 1'b0, 16'd0},
      '{ROW_ITEM, 16'h0123,  16'h5555,  1'b0, pga_pkg::RegCurvature, 1'b0, 16'd0},
      '{ROW_ITEM, 16'hABCD,  16'h2AAA,  1'b0, pga_pkg::RegCurvature, 1'b0, 16'd0},
      '{ROW_ITEM, 16'h8001,  16'd20000, 1'b1, pga_pkg::RegCurvature, 1'b0, 16'd0},
      '{ROW_CFG,  16'd2048,  16'd0,     1'b0, pga_pkg::RegCurvature, 1'b0, 16'd0},
      // Length shortened mid-row: the next element closes the row.
      '{ROW_ITEM, 16'd3000,  16'd0,     1'b0, pga_pkg::RegCurvature, 1'b0, 16'd0},
      '{ROW_ITEM, 16'd9000,  16'd0,     1'b0, pga_pkg::RegCurvature, 1'b0, 16'd0},
      '{ROW_CFG,  16'd1,     16'd0,     1'b0, pga_pkg::RegVecLen,    1'b0, 16'd0},
      '{ROW_ITEM, 16'hC000,  16'd16384, 1'b1, pga_pkg::RegCurvature, 1'b0, 16'd0},
      '{ROW_ITEM, 16'd777,   16'd32768, 1'b1, pga_pkg::RegCurvature, 1'b0, 16'd0}
    };

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG) begin
        write_reg(dir_rows[i].cfg_sel, dir_rows[i].data);
      end else begin
        send_element(dir_rows[i].data, dir_rows[i].weight, dir_rows[i].fin_row);
        if (dir_rows[i].typed) begin
          probe = midpoint_q[$];
          if (probe.coord !== dir_rows[i].typed_val || probe.last !== 1'b1) begin
            $error("midpoint_value: expected %0d, got %0d from the predictor",
                   $signed(dir_rows[i].typed_val), probe.coord);
            mismatches++;
          end
        end
      end
    end

    // Random phases, each with its own configuration and idling pattern.
    n_items = 0;
    mode    = 0;
    while (n_items < RandItems) begin
      case ($urandom_range(0, 4))
        0: write_reg(pga_pkg::RegCurvature, 16'd1);
        1: write_reg(pga_pkg::RegCurvature, 16'd65535);
        2: write_reg(pga_pkg::RegCurvature, pga_pkg::CurvReset);
        default: write_reg(pga_pkg::RegCurvature, 16'($urandom_range(1, 65535)));
      endcase
      if (mode == 5) begin
        write_reg(pga_pkg::RegVecLen, ($urandom_range(0, 1) != 0) ? 16'd100 : 16'd64);
      end else if (mode == 2) begin
        write_reg(pga_pkg::RegVecLen, 16'd0);
      end else begin
        write_reg(pga_pkg::RegVecLen, 16'($urandom_range(1, 8)));
      end
      case (mode % 4)
        0: begin gaps_on = 1'b0; send_idle_pct = 0;  end
        1: begin gaps_on = 1'b1; send_idle_pct = 47; end
        2: begin gaps_on = 1'b0; send_idle_pct = 0;  end
        default: begin gaps_on = 1'b1; send_idle_pct = 17; end
      endcase
      repeat ((mode == 5) ? 130 : 36) begin
        case ($urandom_range(0, 9))
          0: wgt = 16'd32768;
          1: wgt = 16'd0;
          default: wgt = 16'($urandom_range(0, 32767));
        endcase
        send_element(rand_value(), wgt, ($urandom_range(0, 2) == 0));
        n_items++;
      end
      mode++;
    end

    // Close any open set so its results come out, then drain.
    write_reg(pga_pkg::RegVecLen, 16'd1);
    send_element(16'd0, 16'd0, 1'b1);
    start <= 1'b0;
    while (midpoint_q.size() != 0) @(posedge clk_i);
    repeat (400) @(posedge clk_i);

    $display("Covered %0d directed rows and %0d random elements in %0d cycles.",
             dir_rows.size(), n_items, cycles);
    $display("Checked %0d midpoint coordinates from %0d completed sets.",
             results_seen, sets_done);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
